### rtl/tsmc_pkg.sv
// ----------------------------------------------------------------------------
// tsmc_pkg
// Shared types, constants and saturation helpers for the terminal sliding
// mode controller.
// ----------------------------------------------------------------------------
package tsmc_pkg;

  localparam int FRAC_BITS  = 16;
  localparam int DATA_W     = 32;
  localparam int OPND_W     = DATA_W + 1;
  localparam int PROD_W     = 2 * OPND_W;
  localparam int ROOT_W     = 28;
  localparam int SQRT_STEPS = (DATA_W + FRAC_BITS + 1) / 2;
  localparam int SQRT_W     = 2 * SQRT_STEPS;
  localparam int CBRT_STEPS = 28;
  localparam int RAD_W      = 3 * CBRT_STEPS;
  localparam int REM_W      = 64;
  localparam int SQ_W       = 2 * ROOT_W;
  localparam int CNT_W      = 5;
  localparam int CFG_IDX_W  = 4;

  localparam logic [CFG_IDX_W-1:0] REG_TPOS  = 4'd0;
  localparam logic [CFG_IDX_W-1:0] REG_TVEL  = 4'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SGAIN = 4'd2;
  localparam logic [CFG_IDX_W-1:0] REG_PGAIN = 4'd3;
  localparam logic [CFG_IDX_W-1:0] REG_WGAIN = 4'd4;
  localparam logic [CFG_IDX_W-1:0] REG_TSTEP = 4'd5;
  localparam logic [CFG_IDX_W-1:0] REG_ILIM  = 4'd6;
  localparam logic [CFG_IDX_W-1:0] REG_OLIM  = 4'd7;

  localparam logic [63:0] ILIM_RAW = 64'd5000 << FRAC_BITS;
  localparam logic [30:0] ILIM_RESET =
      (ILIM_RAW > 64'h7FFF_FFFF) ? 31'h7FFF_FFFF : ILIM_RAW[30:0];

  typedef enum logic {
    ROOT_SQRT,
    ROOT_CBRT
  } root_mode_e;

  typedef struct packed {
    logic       start;
    root_mode_e mode;
  } root_req_t;

  localparam logic signed [PROD_W-1:0] SAT_MAX = PROD_W'(64'sh7FFF_FFFF);
  localparam logic signed [PROD_W-1:0] SAT_MIN = -PROD_W'(64'sh8000_0000);

  function automatic logic signed [DATA_W-1:0] sat32(input logic signed [PROD_W-1:0] v);
    logic signed [DATA_W-1:0] r;
    if (v > SAT_MAX) r = 32'sh7FFF_FFFF;
    else if (v < SAT_MIN) r = 32'sh8000_0000;
    else r = v[DATA_W-1:0];
    return r;
  endfunction

  // floor(p / 2^F), saturated
  function automatic logic signed [DATA_W-1:0] take(input logic signed [PROD_W-1:0] p);
    return sat32(p >>> FRAC_BITS);
  endfunction

endpackage

### rtl/tsmc_mul.sv
// ----------------------------------------------------------------------------
// tsmc_mul
// Shared signed multiplier with registered product.
// ----------------------------------------------------------------------------
module tsmc_mul (
  input  logic                                clk_i,
  input  logic signed [tsmc_pkg::OPND_W-1:0]  a_i,
  input  logic signed [tsmc_pkg::OPND_W-1:0]  b_i,
  output logic signed [tsmc_pkg::PROD_W-1:0]  prod_o
);
  import tsmc_pkg::*;

  logic signed [PROD_W-1:0] prod_q;

  always_ff @(posedge clk_i) begin
    prod_q <= PROD_W'(a_i) * PROD_W'(b_i);
  end

  assign prod_o = prod_q;

endmodule

### rtl/tsmc_root.sv
// ----------------------------------------------------------------------------
// tsmc_root
// Digit-by-digit square root (2 bits a step) and cube root (3 bits a step),
// shift and add only, sharing one remainder datapath.
// ----------------------------------------------------------------------------
module tsmc_root (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  tsmc_pkg::root_req_t           req_i,
  input  logic [tsmc_pkg::DATA_W-1:0]   mag_i,
  output logic                          done_o,
  output logic [tsmc_pkg::ROOT_W-1:0]   root_o
);
  import tsmc_pkg::*;

  logic             busy_q, busy_d;
  logic             done_q, done_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  root_mode_e       mode_q, mode_d;
  logic [RAD_W-1:0] rad_q, rad_d;
  logic [REM_W-1:0] rem_q, rem_d;
  logic [ROOT_W-1:0] y_q, y_d;
  logic [SQ_W-1:0]  y2_q, y2_d;

  logic [REM_W+2:0] r_w;
  logic [REM_W+2:0] t_w;
  logic             fit;

  always_comb begin
    if (mode_q == ROOT_SQRT) begin
      r_w = {1'b0, rem_q, rad_q[RAD_W-1 -: 2]};
      t_w = (REM_W + 3)'({y_q, 2'b01});
    end else begin
      r_w = {rem_q, rad_q[RAD_W-1 -: 3]};
      // 3*y'(y'+1)+1 with y' = 2y
      t_w = (REM_W + 3)'({y2_q, 3'b000}) + (REM_W + 3)'({y2_q, 2'b00})
          + (REM_W + 3)'({y_q, 2'b00}) + (REM_W + 3)'({y_q, 1'b0}) + (REM_W + 3)'(1);
    end
    fit = (r_w >= t_w);
  end

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    mode_d = mode_q;
    rad_d  = rad_q;
    rem_d  = rem_q;
    y_d    = y_q;
    y2_d   = y2_q;
    if (req_i.start) begin
      busy_d = 1'b1;
      mode_d = req_i.mode;
      rem_d  = '0;
      y_d    = '0;
      y2_d   = '0;
      if (req_i.mode == ROOT_SQRT) begin
        rad_d = {SQRT_W'({mag_i, {FRAC_BITS{1'b0}}}), {(RAD_W - SQRT_W){1'b0}}};
        cnt_d = CNT_W'(SQRT_STEPS - 1);
      end else begin
        rad_d = RAD_W'({mag_i, {(2 * FRAC_BITS){1'b0}}});
        cnt_d = CNT_W'(CBRT_STEPS - 1);
      end
    end else if (busy_q) begin
      if (mode_q == ROOT_SQRT) begin
        rad_d = rad_q << 2;
        if (fit) begin
          rem_d = REM_W'(r_w - t_w);
          y_d   = {y_q[ROOT_W-2:0], 1'b1};
        end else begin
          rem_d = REM_W'(r_w);
          y_d   = {y_q[ROOT_W-2:0], 1'b0};
        end
      end else begin
        rad_d = rad_q << 3;
        if (fit) begin
          rem_d = REM_W'(r_w - t_w);
          y_d   = {y_q[ROOT_W-2:0], 1'b1};
          y2_d  = {y2_q[SQ_W-3:0], 2'b00} + SQ_W'({y_q, 2'b00}) + SQ_W'(1);
        end else begin
          rem_d = REM_W'(r_w);
          y_d   = {y_q[ROOT_W-2:0], 1'b0};
          y2_d  = {y2_q[SQ_W-3:0], 2'b00};
        end
      end
      if (cnt_q == '0) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end else begin
        cnt_d = cnt_q - CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
      mode_q <= ROOT_SQRT;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
      mode_q <= mode_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rad_q <= rad_d;
    rem_q <= rem_d;
    y_q   <= y_d;
    y2_q  <= y2_d;
  end

  assign done_o = done_q;
  assign root_o = y_q;

endmodule

### rtl/terminal_sliding_mode_controller.sv
// ----------------------------------------------------------------------------
// terminal_sliding_mode_controller
// Sequencer, registers and state around the shared multiplier and root unit.
// ----------------------------------------------------------------------------
// Sequence: a control update takes 24 square-root steps, 28 cube-root steps
// and four multiplies in the shared unit, and registers its result once the
// output register is free; the controller is then idle for the next transaction.
// A clear transaction clears the integrator without leaving idle and gives no result.
// Throughput: one transaction at a time; input ready only while idle.
// Reset: asynchronous, active low; registers to defaults, integrator to zero.
module terminal_sliding_mode_controller (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  in_valid_i,
  output logic                                  in_ready_o,
  input  logic                                  operation_i,
  input  logic signed [tsmc_pkg::DATA_W-1:0]    measured_position_i,
  input  logic signed [tsmc_pkg::DATA_W-1:0]    measured_velocity_i,
  output logic                                  out_valid_o,
  input  logic                                  out_ready_i,
  output logic signed [tsmc_pkg::DATA_W-1:0]    drive_o,
  input  logic                                  cfg_valid_i,
  output logic                                  cfg_ready_o,
  input  logic [tsmc_pkg::CFG_IDX_W-1:0]        cfg_index_i,
  input  logic [tsmc_pkg::DATA_W-1:0]           cfg_data_i
);
  import tsmc_pkg::*;

  localparam logic [3:0] ST_IDLE  = 4'd0;
  localparam logic [3:0] ST_PREP  = 4'd1;
  localparam logic [3:0] ST_SQRT  = 4'd2;
  localparam logic [3:0] ST_MPW   = 4'd3;
  localparam logic [3:0] ST_TPW   = 4'd4;
  localparam logic [3:0] ST_MTERM = 4'd5;
  localparam logic [3:0] ST_TTERM = 4'd6;
  localparam logic [3:0] ST_MINT  = 4'd7;
  localparam logic [3:0] ST_TINT  = 4'd8;
  localparam logic [3:0] ST_CBRT  = 4'd9;
  localparam logic [3:0] ST_MDRV  = 4'd10;
  localparam logic [3:0] ST_TDRV  = 4'd11;

  logic [3:0] state_q, state_d;

  logic signed [DATA_W-1:0] tpos_q, tvel_q, sgain_q, pgain_q, wgain_q;
  logic [DATA_W-2:0]        tstep_q, ilim_q, olim_q;
  logic signed [DATA_W-1:0] integ_q, integ_d;
  logic signed [DATA_W-1:0] e_q, e_d, ev_q, ev_d, pw_q, pw_d, s_q, s_d;
  logic signed [DATA_W-1:0] drive_q, drive_d;
  logic                     out_valid_q, out_valid_d;

  logic signed [OPND_W-1:0] mul_a, mul_b;
  logic signed [PROD_W-1:0] prod;
  root_req_t                root_req;
  logic [DATA_W-1:0]        root_mag;
  logic                     root_done;
  logic [ROOT_W-1:0]        root_val;

  logic [DATA_W-1:0]        ev_mag, s_mag;
  logic signed [DATA_W-1:0] pw_pos, sum_drv;
  logic signed [OPND_W-1:0] root_sgn;

  function automatic logic signed [DATA_W-1:0] clamp_mag(
      input logic signed [DATA_W-1:0] v, input logic [DATA_W-2:0] lim);
    logic signed [DATA_W:0] vx, lx;
    logic signed [DATA_W-1:0] r;
    vx = {v[DATA_W-1], v};
    lx = {2'b00, lim};
    r  = v;
    if (lim != '0) begin
      if (vx > lx) r = {1'b0, lim};
      else if (vx < -lx) r = DATA_W'(-lx);
    end
    return r;
  endfunction

  assign ev_mag = ev_q[DATA_W-1] ? DATA_W'(-ev_q) : ev_q;
  assign s_mag  = s_q[DATA_W-1] ? DATA_W'(-s_q) : s_q;
  assign pw_pos = take(prod);
  assign root_sgn = s_q[DATA_W-1] ? -OPND_W'({1'b0, root_val}) : OPND_W'({1'b0, root_val});
  assign sum_drv = sat32(PROD_W'(integ_q) + PROD_W'(take(prod)));

  tsmc_mul u_mul (
    .clk_i  (clk_i),
    .a_i    (mul_a),
    .b_i    (mul_b),
    .prod_o (prod)
  );

  tsmc_root u_root (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (root_req),
    .mag_i  (root_mag),
    .done_o (root_done),
    .root_o (root_val)
  );

  assign in_ready_o  = (state_q == ST_IDLE);
  assign cfg_ready_o = 1'b1;

  always_comb begin
    state_d     = state_q;
    integ_d     = integ_q;
    e_d         = e_q;
    ev_d        = ev_q;
    pw_d        = pw_q;
    s_d         = s_q;
    drive_d     = drive_q;
    out_valid_d = out_valid_q && !out_ready_i;
    mul_a       = '0;
    mul_b       = '0;
    root_req    = '{start: 1'b0, mode: ROOT_SQRT};
    root_mag    = ev_mag;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          if (operation_i) begin
            integ_d = '0;
          end else begin
            e_d  = sat32(PROD_W'(tpos_q) - PROD_W'(measured_position_i));
            ev_d = sat32(PROD_W'(tvel_q) - PROD_W'(measured_velocity_i));
            state_d = ST_PREP;
          end
        end
      end
      ST_PREP: begin
        root_req = '{start: 1'b1, mode: ROOT_SQRT};
        state_d  = ST_SQRT;
      end
      ST_SQRT: begin
        if (root_done) state_d = ST_MPW;
      end
      ST_MPW: begin
        mul_a   = OPND_W'({1'b0, ev_mag});
        mul_b   = OPND_W'({1'b0, root_val});
        state_d = ST_TPW;
      end
      ST_TPW: begin
        pw_d    = ev_q[DATA_W-1] ? -pw_pos : pw_pos;
        state_d = ST_MTERM;
      end
      ST_MTERM: begin
        mul_a   = OPND_W'(sgain_q);
        mul_b   = OPND_W'(pw_q);
        state_d = ST_TTERM;
      end
      ST_TTERM: begin
        s_d     = sat32(PROD_W'(e_q) + PROD_W'(take(prod)));
        state_d = ST_MINT;
      end
      ST_MINT: begin
        integ_d = clamp_mag(integ_q, ilim_q);
        if (s_q[DATA_W-1]) mul_a = -OPND_W'(wgain_q);
        else if (s_q != '0) mul_a = OPND_W'(wgain_q);
        else mul_a = '0;
        mul_b    = OPND_W'({1'b0, tstep_q});
        root_req = '{start: 1'b1, mode: ROOT_CBRT};
        root_mag = s_mag;
        state_d  = ST_TINT;
      end
      ST_TINT: begin
        integ_d = sat32(PROD_W'(integ_q) + PROD_W'(take(prod)));
        state_d = ST_CBRT;
      end
      ST_CBRT: begin
        if (root_done) state_d = ST_MDRV;
      end
      ST_MDRV: begin
        mul_a   = OPND_W'(pgain_q);
        mul_b   = root_sgn;
        state_d = ST_TDRV;
      end
      ST_TDRV: begin
        // hold the product until the output register is free
        mul_a = OPND_W'(pgain_q);
        mul_b = root_sgn;
        if (!out_valid_q || out_ready_i) begin
          drive_d     = clamp_mag(sum_drv, olim_q);
          out_valid_d = 1'b1;
          state_d     = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
      integ_q     <= '0;
      tpos_q      <= '0;
      tvel_q      <= '0;
      sgain_q     <= '0;
      pgain_q     <= '0;
      wgain_q     <= '0;
      tstep_q     <= '0;
      ilim_q      <= ILIM_RESET;
      olim_q      <= '0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      integ_q     <= integ_d;
      if (cfg_valid_i) begin
        case (cfg_index_i)
          REG_TPOS:  tpos_q  <= cfg_data_i;
          REG_TVEL:  tvel_q  <= cfg_data_i;
          REG_SGAIN: sgain_q <= cfg_data_i;
          REG_PGAIN: pgain_q <= cfg_data_i;
          REG_WGAIN: wgain_q <= cfg_data_i;
          REG_TSTEP: tstep_q <= cfg_data_i[DATA_W-2:0];
          REG_ILIM:  ilim_q  <= cfg_data_i[DATA_W-2:0];
          REG_OLIM:  olim_q  <= cfg_data_i[DATA_W-2:0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    e_q     <= e_d;
    ev_q    <= ev_d;
    pw_q    <= pw_d;
    s_q     <= s_d;
    drive_q <= drive_d;
  end

  assign out_valid_o = out_valid_q;
  assign drive_o     = drive_q;

endmodule

### dv/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the terminal sliding mode controller. A table of
// directed updates and clears runs first, then randomised transactions under
// several register settings. Each accepted update is predicted in the bench
// and each drive result is compared in order against the predicted value.
// ----------------------------------------------------------------------------
module testbench;
  import tsmc_pkg::*;

  localparam int  FB          = FRAC_BITS;
  localparam int  SETTLE      = 80;
  localparam int  CYCLE_LIMIT = 1_000_000;
  localparam logic [31:0] MAXV = 32'h7FFF_FFFF;
  localparam logic [31:0] MINV = 32'h8000_0000;
  localparam bit  OP_UPDATE   = 1'b0;
  localparam bit  OP_CLEAR    = 1'b1;
  localparam logic [CFG_IDX_W-1:0] REG_NONE = 4'd9;

  logic                     clk_i = 1'b0;
  logic                     rst_ni = 1'b0;
  logic                     in_valid_i = 1'b0;
  logic                     in_ready_o;
  logic                     operation_i = 1'b0;
  logic signed [DATA_W-1:0] measured_position_i = '0;
  logic signed [DATA_W-1:0] measured_velocity_i = '0;
  logic                     out_valid_o;
  logic                     out_ready_i = 1'b0;
  logic signed [DATA_W-1:0] drive_o;
  logic                     cfg_valid_i = 1'b0;
  logic                     cfg_ready_o;
  logic [CFG_IDX_W-1:0]     cfg_index_i = '0;
  logic [DATA_W-1:0]        cfg_data_i = '0;

  terminal_sliding_mode_controller dut (.*);

  always #5 clk_i = ~clk_i;

  // controller state as the bench sees it
  longint tgt_pos, tgt_vel, surf_gain, prop_gain, sw_gain, dt, integ_lim, drive_lim;
  longint integ;

  logic signed [DATA_W-1:0] drive_q[$];
  int  errors = 0;
  int  cycles = 0;
  int  tx_idle = 0;
  int  rx_idle = 0;
  bit  hold_req = 1'b0;
  int  hold_cnt = 0;

  typedef struct {
    bit          op;
    logic [31:0] pos;
    logic [31:0] vel;
  } stim_row_t;

  stim_row_t stim_tbl[$] = '{
    '{OP_UPDATE, 32'h0, 32'h0},
    '{OP_UPDATE, MAXV, MAXV},
    '{OP_UPDATE, MINV, MINV},
    '{OP_UPDATE, MAXV, MINV},
    '{OP_UPDATE, MINV, MAXV},
    '{OP_UPDATE, 32'h1, 32'hFFFF_FFFF},
    '{OP_UPDATE, 32'hFFFF_FFFF, 32'h1},
    '{OP_UPDATE, 32'h0001_0000, 32'hFFFF_0000},
    '{OP_CLEAR,  32'h0, 32'h0},
    '{OP_UPDATE, 32'h5555_5555, 32'hAAAA_AAAA},
    '{OP_UPDATE, 32'hAAAA_AAAA, 32'h5555_5555},
    '{OP_CLEAR,  MAXV, MINV},
    '{OP_UPDATE, 32'h0000_0001, 32'h0000_0000},
    '{OP_UPDATE, 32'h0000_0000, 32'h0000_0001},
    '{OP_UPDATE, 32'h0064_0000, 32'hFF9C_0000},
    '{OP_UPDATE, 32'hFFF0_0000, 32'h0010_0000},
    '{OP_CLEAR,  32'hFFFF_FFFF, 32'hFFFF_FFFF},
    '{OP_UPDATE, MINV, 32'h0},
    '{OP_UPDATE, 32'h0, MINV},
    '{OP_UPDATE, MAXV, 32'h0}
  };

  function automatic longint sat32_l(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  // floor(a*b / 2^F); arithmetic shift rounds towards minus infinity
  function automatic longint qmul(longint a, longint b);
    longint p;
    p = a * b;
    return sat32_l(p >>> FB);
  endfunction

  function automatic longint unsigned sqrt_floor(longint unsigned n);
    longint unsigned res, bitv;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > n) bitv >>= 2;
    while (bitv != 0) begin
      if (n >= res + bitv) begin
        n -= res + bitv;
        res = (res >> 1) + bitv;
      end else begin
        res >>= 1;
      end
      bitv >>= 2;
    end
    return res;
  endfunction

  function automatic longint unsigned cbrt_floor(longint unsigned x);
    logic [127:0] cand, lim;
    logic [27:0]  y;
    y = '0;
    lim = {64'd0, x} << (2 * FB);
    for (int b = 27; b >= 0; b--) begin
      cand = {100'd0, y | (28'd1 << b)};
      if (cand * cand * cand <= lim) y = y | (28'd1 << b);
    end
    return longint'(y);
  endfunction

  function automatic longint clamp_mag(longint v, longint lim);
    if (v > lim) return lim;
    if (v < -lim) return -lim;
    return v;
  endfunction

  function automatic longint next_drive(logic signed [31:0] pos, logic signed [31:0] vel);
    longint e, ev, pw, s, sg, drv;
    longint unsigned mag, root;
    e  = sat32_l(tgt_pos - longint'(pos));
    ev = sat32_l(tgt_vel - longint'(vel));
    mag = (ev < 0) ? -ev : ev;
    root = sqrt_floor(mag << FB);
    pw = sat32_l(longint'((mag * root) >> FB));
    if (ev < 0) pw = -pw;
    s = sat32_l(e + qmul(surf_gain, pw));
    if (integ_lim != 0) integ = clamp_mag(integ, integ_lim);
    sg = (s > 0) ? sw_gain : ((s < 0) ? -sw_gain : 0);
    integ = sat32_l(integ + qmul(sg, dt));
    mag = (s < 0) ? -s : s;
    pw = longint'(cbrt_floor(mag));
    if (s < 0) pw = -pw;
    drv = sat32_l(integ + qmul(prop_gain, pw));
    if (drive_lim != 0) drv = clamp_mag(drv, drive_lim);
    return drv;
  endfunction

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    cfg_valid_i <= 1'b0;
    case (idx)
      REG_TPOS:  tgt_pos   = longint'(signed'(data));
      REG_TVEL:  tgt_vel   = longint'(signed'(data));
      REG_SGAIN: surf_gain = longint'(signed'(data));
      REG_PGAIN: prop_gain = longint'(signed'(data));
      REG_WGAIN: sw_gain   = longint'(signed'(data));
      REG_TSTEP: dt        = longint'({33'd0, data[30:0]});
      REG_ILIM:  integ_lim = longint'({33'd0, data[30:0]});
      REG_OLIM:  drive_lim = longint'({33'd0, data[30:0]});
      default: ;
    endcase
  endtask

  // typed: push the given value in place of the prediction (state still advances)
  task automatic send_item(bit op, logic [31:0] pos, logic [31:0] vel,
                           bit typed, logic [31:0] typed_drive);
    longint drv;
    bit     rdy;
    while ($urandom_range(0, 99) < tx_idle) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i          <= 1'b1;
    operation_i         <= op;
    measured_position_i <= pos;
    measured_velocity_i <= vel;
    // ready is sampled mid-cycle so the edge that takes the transaction is known
    do begin
      @(negedge clk_i);
      rdy = in_ready_o;
      @(posedge clk_i);
    end while (!rdy);
    if (op == OP_CLEAR) begin
      integ = 0;
    end else begin
      drv = next_drive(pos, vel);
      drive_q.push_back(typed ? typed_drive : drv[31:0]);
    end
  endtask

  task automatic wait_idle();
    in_valid_i <= 1'b0;
    while (drive_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  function automatic logic [31:0] pick_word();
    case ($urandom_range(0, 9))
      0: return MAXV;
      1: return MINV;
      2: return 32'h0;
      3, 4: return $urandom_range(0, 1) ? $urandom_range(0, 32'h0010_0000)
                                        : -$urandom_range(0, 32'h0010_0000);
      default: return $urandom;
    endcase
  endfunction

  // mostly samples close to the setpoints so the surface stays in range
  task automatic random_items(int n);
    logic [31:0] pos, vel;
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 3) == 0) begin
        pos = pick_word();
        vel = pick_word();
      end else begin
        pos = tgt_pos[31:0] + ($urandom_range(0, 32'h0008_0000) - 32'h0004_0000);
        vel = tgt_vel[31:0] + ($urandom_range(0, 32'h0004_0000) - 32'h0002_0000);
      end
      send_item(($urandom_range(0, 9) == 0) ? OP_CLEAR : OP_UPDATE, pos, vel, 1'b0, '0);
    end
  endtask

  task automatic run_table(bit typed);
    foreach (stim_tbl[i])
      send_item(stim_tbl[i].op, stim_tbl[i].pos, stim_tbl[i].vel, typed, 32'h0);
  endtask

  function automatic logic [31:0] rand_gain();
    logic [31:0] g;
    g = $urandom_range(0, 8 << FB);
    return $urandom_range(0, 1) ? g : -g;
  endfunction

  task automatic random_regs();
    write_reg(REG_TPOS, pick_word());
    write_reg(REG_TVEL, pick_word());
    write_reg(REG_SGAIN, rand_gain());
    write_reg(REG_PGAIN, rand_gain());
    write_reg(REG_WGAIN, rand_gain());
    // bit 31 set at random: upper bit of the narrow registers must be dropped
    write_reg(REG_TSTEP, {1'($urandom), 31'($urandom_range(0, 1 << 14))});
    write_reg(REG_ILIM, ($urandom_range(0, 3) == 0) ? {1'($urandom), 31'd0}
                                                    : {1'($urandom), 31'($urandom_range(1, 100 << FB))});
    write_reg(REG_OLIM, ($urandom_range(0, 2) == 0) ? {1'($urandom), 31'd0}
                                                    : {1'($urandom), 31'($urandom_range(1, 200 << FB))});
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
      hold_cnt    <= 0;
    end else if (hold_cnt > 0) begin
      out_ready_i <= 1'b0;
      hold_cnt    <= hold_cnt - 1;
    end else if (hold_req) begin
      out_ready_i <= 1'b0;
      hold_cnt    <= 400;
    end else begin
      out_ready_i <= ($urandom_range(0, 99) >= rx_idle);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (drive_q.size() == 0) begin
        $error("drive: no transaction expected, got %0d", drive_o);
        errors++;
      end else begin
        logic signed [31:0] want;
        want = drive_q.pop_front();
        if (drive_o !== want) begin
          $error("drive: expected %0d, got %0d", want, drive_o);
          errors++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("testbench failed");
      $finish;
    end
  end

  initial begin
    tgt_pos = 0; tgt_vel = 0; surf_gain = 0; prop_gain = 0; sw_gain = 0; dt = 0;
    integ_lim = longint'({33'd0, ILIM_RESET}); drive_lim = 0; integ = 0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // all gains zero out of reset, so every update drives zero
    tx_idle = 16; rx_idle = 69;
    run_table(1'b1);
    random_items(100);

    for (int ph = 1; ph <= 6; ph++) begin
      wait_idle();
      if (ph == 1) begin
        write_reg(REG_TPOS, MAXV);
        write_reg(REG_TVEL, MINV);
        write_reg(REG_SGAIN, MAXV);
        write_reg(REG_PGAIN, MINV);
        write_reg(REG_WGAIN, MAXV);
        write_reg(REG_TSTEP, 32'hFFFF_FFFF);
        write_reg(REG_ILIM, 32'h0);
        write_reg(REG_OLIM, 32'h8000_0000);
        write_reg(REG_NONE, 32'h1234_5678);
      end else if (ph == 2) begin
        write_reg(REG_TPOS, MINV);
        write_reg(REG_TVEL, MAXV);
        write_reg(REG_SGAIN, MINV);
        write_reg(REG_PGAIN, MAXV);
        write_reg(REG_WGAIN, MINV);
        write_reg(REG_TSTEP, 32'h0);
        write_reg(REG_ILIM, MAXV);
        write_reg(REG_OLIM, 32'h1);
      end else begin
        random_regs();
      end
      if (ph == 3) begin
        tx_idle = 69; rx_idle = 16;
      end else if (ph == 5) begin
        tx_idle = 0; rx_idle = 0;
      end
      if (ph <= 2) run_table(1'b0);
      if (ph == 4) begin
        // long receiver stall while items keep coming
        hold_req = 1'b1;
        repeat (2) @(posedge clk_i);
        hold_req = 1'b0;
      end
      random_items(ph <= 2 ? 120 : 220);
    end

    wait_idle();
    if (errors == 0) begin
      $display("testbench passed");
    end else begin
      $display("testbench failed");
    end
    $finish;
  end

endmodule
